FILE: rtl/core/mnso_pkg.sv
// Package for the MIDI note sine oscillator: shared types, constants and
// the elaboration-time sine table function. No dependencies.
package mnso_pkg;

	// Fixed field widths
	localparam int NOTE_COUNT  = 128;
	localparam int NOTE_BITS   = 7;
	localparam int STATUS_BITS = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int S_DATA_BITS = 24;

	// Defaults for the top-level parameters
	localparam int DEFAULT_SAMPLE_RATE    = 48000;
	localparam int DEFAULT_PHASE_BITS     = 32;
	localparam int DEFAULT_SINE_ADDR_BITS = 10;

	// Command queue between the front and the back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	// MIDI status high nibbles
	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

	// Division by 127 through a reciprocal: floor(a / 127) = (a * RECIP) >> SHIFT
	// for every a below 2^22.
	localparam int            MAG_BITS     = 22;
	localparam int            RECIP_BITS   = 25;
	localparam int            PROD_BITS    = 24;
	localparam logic [24:0]   DIV127_RECIP = 25'd16909321;
	localparam int            DIV127_SHIFT = 31;
	localparam logic [21:0]   ROUND_BIAS   = 22'd63;

	// Semitone ratios 2^(k/12) in Q1.20
	localparam longint unsigned SEMITONE_Q20 [12] = '{
		64'd1048576, 64'd1110928, 64'd1176987, 64'd1246974,
		64'd1321123, 64'd1399681, 64'd1482910, 64'd1571089,
		64'd1664511, 64'd1763488, 64'd1868350, 64'd1979448
	};

	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Decoded event kinds
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_ON,
		CMD_OFF
	} cmd_kind_t;

	// One classified item as it travels through the queue
	typedef struct packed {
		cmd_kind_t            kind;
		logic [NOTE_BITS-1:0] note;
		logic [NOTE_BITS-1:0] vel;
	} cmd_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Quarter-wave sine, round(32767 * sin(pi/2 * j / quarter)), where
	// quarter is 2^(abits-2). Integer Taylor series in Q30 up to x^11.
	function automatic longint unsigned quarter_sine(input int abits, input longint unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		x  = (HALF_PI_Q30 * j) >> (abits - 2);
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		v  = (64'd32767 * s + (Q30_ONE >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v;
	endfunction

	// Full-wave sine table entry i, mirrored from the quarter wave.
	function automatic logic signed [SAMPLE_BITS-1:0] sine_value(input int abits, input int i);
		longint unsigned n;
		longint unsigned quarter;
		longint unsigned idx;
		longint unsigned v;
		logic [SAMPLE_BITS-1:0] r;
		n       = 64'd1 << abits;
		quarter = n >> 2;
		idx     = longint'(i);
		if (idx < quarter) begin
			v = quarter_sine(abits, idx);
			r = v[SAMPLE_BITS-1:0];
		end else if (idx < 2 * quarter) begin
			v = quarter_sine(abits, 2 * quarter - idx);
			r = v[SAMPLE_BITS-1:0];
		end else if (idx < 3 * quarter) begin
			v = quarter_sine(abits, idx - 2 * quarter);
			r = -v[SAMPLE_BITS-1:0];
		end else begin
			v = quarter_sine(abits, n - idx);
			r = -v[SAMPLE_BITS-1:0];
		end
		return $signed(r);
	endfunction

endpackage

FILE: rtl/core/mnso_front.sv
// Front part of the MIDI note sine oscillator: accepts input transactions
// and classifies the MIDI event they carry. Depends on mnso_pkg.
module mnso_front import mnso_pkg::*; (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata fields, low bit up: status_byte[7:0], note_number[14:8],
	// velocity[21:15], zero fill [23:22]
	input  logic [S_DATA_BITS-1:0] s_tdata,
	// s_tuser fields: event_valid[0]
	input  logic                   s_tuser,
	input  q_status_t              q_status,
	output logic                   push,
	output cmd_t                   push_cmd
);

	logic [3:0] status_hi;

	// Accept whenever the queue has room.
	assign s_tready  = !q_status.full;
	assign push      = s_tvalid && s_tready;
	assign status_hi = s_tdata[7:4];

	// Decode the event; the channel nibble plays no part.
	always_comb begin
		push_cmd.note = s_tdata[14:8];
		push_cmd.vel  = s_tdata[21:15];
		push_cmd.kind = CMD_NONE;
		if (s_tuser) begin
			case (status_hi)
				STATUS_NOTE_ON:  push_cmd.kind = CMD_ON;
				STATUS_NOTE_OFF: push_cmd.kind = CMD_OFF;
				default:         push_cmd.kind = CMD_NONE;
			endcase
		end
	end

endmodule

FILE: rtl/core/mnso_queue.sv
// Short command queue between the front and the back of the MIDI note sine
// oscillator, so that either side can stall alone. Depends on mnso_pkg.
module mnso_queue import mnso_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t q_status
);

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign q_status.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_cmd        = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// The back never takes a command from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	// A lone write raises the count by one.
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a write");

	// A lone read lowers the count by one.
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not follow a read");

endmodule

FILE: rtl/core/mnso_back.sv
// Back part of the MIDI note sine oscillator: applies note events, runs the
// phase accumulator, reads the sine table and scales by velocity / 127.
// Depends on mnso_pkg.
module mnso_back import mnso_pkg::*; #(
	parameter int SAMPLE_RATE    = DEFAULT_SAMPLE_RATE,
	parameter int PHASE_BITS     = DEFAULT_PHASE_BITS,
	parameter int SINE_ADDR_BITS = DEFAULT_SINE_ADDR_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   pop_cmd,
	input  q_status_t              q_status,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata fields: sample[15:0]
	output logic [SAMPLE_BITS-1:0] m_tdata
);

	localparam int              SINE_SIZE = 1 << SINE_ADDR_BITS;
	localparam longint unsigned SR        = longint'(SAMPLE_RATE);

	// Phase increment of note n: 27.5 * 2^((n-9)/12) Hz as a fraction of a
	// cycle per sample, scaled by 2^PHASE_BITS.
	function automatic longint unsigned inc_value(input int n);
		int              t;
		int              oct;
		int              k;
		int              e;
		longint unsigned v;
		longint unsigned q;
		longint unsigned r;
		t   = n + 3;
		oct = t / 12;
		k   = t % 12;
		v   = 64'd55 * SEMITONE_Q20[k];
		e   = oct + PHASE_BITS - 22;
		q   = v / SR;
		r   = v % SR;
		if (e >= 0) begin
			return (q << e) + ((r << e) / SR);
		end else begin
			return q >> (-e);
		end
	endfunction

	logic [PHASE_BITS-1:0]         inc_tab  [NOTE_COUNT];
	logic signed [SAMPLE_BITS-1:0] sine_tab [SINE_SIZE];

	// Constant tables, worked out at elaboration.
	for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_inc
		localparam longint unsigned INC = inc_value(g);
		assign inc_tab[g] = INC[PHASE_BITS-1:0];
	end

	for (genvar g = 0; g < SINE_SIZE; g++) begin : g_sine
		localparam logic signed [SAMPLE_BITS-1:0] SINE = sine_value(SINE_ADDR_BITS, g);
		assign sine_tab[g] = SINE;
	end

	logic                          adv;
	logic [NOTE_BITS-1:0]          note_next;
	logic [NOTE_BITS-1:0]          amp_next;
	logic [PHASE_BITS-1:0]         phase_next;
	logic [SINE_ADDR_BITS-1:0]     sine_addr;
	logic signed [PROD_BITS-1:0]   prod_abs;
	logic [MAG_BITS-1:0]           mag;
	logic [SAMPLE_BITS-1:0]        quot;

	// Note state and phase: stage one of the pipeline.
	logic [PHASE_BITS-1:0]         phase_q;
	logic [NOTE_BITS-1:0]          note_q;
	logic [NOTE_BITS-1:0]          amp_q;
	logic                          valid_s1;

	logic signed [SAMPLE_BITS-1:0] sine_s2;
	logic [NOTE_BITS-1:0]          amp_s2;
	logic                          valid_s2;
	logic signed [PROD_BITS-1:0]   prod_s3;
	logic                          valid_s3;
	logic [MAG_BITS+RECIP_BITS-1:0] rprod_s4;
	logic                          neg_s4;
	logic                          valid_s4;
	logic [SAMPLE_BITS-1:0]        sample_q;
	logic                          out_valid_q;

	// The whole pipeline moves when the output register is free.
	assign adv      = !out_valid_q || m_tready;
	assign pop      = adv && !q_status.empty;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = sample_q;

	// Apply the event before the phase advances.
	always_comb begin
		note_next = note_q;
		amp_next  = amp_q;
		case (pop_cmd.kind)
			CMD_ON: begin
				note_next = pop_cmd.note;
				amp_next  = pop_cmd.vel;
			end
			CMD_OFF: begin
				note_next = pop_cmd.note;
				amp_next  = '0;
			end
			CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign phase_next = phase_q + inc_tab[note_next];
	assign sine_addr  = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];

	// Magnitude plus the rounding bias for the division by 127.
	assign prod_abs = prod_s3[PROD_BITS-1] ? -prod_s3 : prod_s3;
	assign mag      = prod_abs[MAG_BITS-1:0] + ROUND_BIAS;
	assign quot     = rprod_s4[DIV127_SHIFT +: SAMPLE_BITS];

	// Oscillator state and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			note_q      <= '0;
			amp_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_next;
				note_q  <= note_next;
				amp_q   <= amp_next;
			end
			if (adv) begin
				valid_s1    <= !q_status.empty;
				valid_s2    <= valid_s1;
				valid_s3    <= valid_s2;
				valid_s4    <= valid_s3;
				out_valid_q <= valid_s4;
			end
		end
	end

	// Sine lookup, scaling and rounding.
	always_ff @(posedge clk) begin
		if (adv) begin
			sine_s2  <= sine_tab[sine_addr];
			amp_s2   <= amp_q;
			prod_s3  <= PROD_BITS'($signed({1'b0, amp_s2})) * PROD_BITS'(sine_s2);
			rprod_s4 <= (MAG_BITS+RECIP_BITS)'(mag) * (MAG_BITS+RECIP_BITS)'(DIV127_RECIP);
			neg_s4   <= prod_s3[PROD_BITS-1];
			sample_q <= neg_s4 ? -quot : quot;
		end
	end

endmodule

FILE: rtl/core/midi_note_sine_oscillator.sv
// Top level of the MIDI note sine oscillator: front, command queue and back.
// Depends on mnso_pkg, mnso_front, mnso_queue and mnso_back.
//
// One input transaction per audio sample, one output sample per input
// transaction. The block takes an item every clock cycle unless the output
// stalls; the rate is set by the phase accumulator loop, which reads the
// note increment table and adds it to the phase combinationally. An item
// goes from the queue through the phase, sine, product, reciprocal product
// and output registers. A four-entry command queue between the input side
// and the oscillator pipeline lets either side stall on its own. Note-on
// (status 0x9n) sets the note and the velocity as amplitude, note-off (0x8n)
// sets the note and silences it; other statuses and the channel are ignored.
// The sine table has 2^SINE_ADDR_BITS entries and a registered read output.
module midi_note_sine_oscillator import mnso_pkg::*; #(
	parameter int SAMPLE_RATE    = DEFAULT_SAMPLE_RATE,
	parameter int PHASE_BITS     = DEFAULT_PHASE_BITS,
	parameter int SINE_ADDR_BITS = DEFAULT_SINE_ADDR_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata fields, low bit up: status_byte[7:0], note_number[14:8],
	// velocity[21:15], zero fill [23:22]
	input  logic [S_DATA_BITS-1:0] s_tdata,
	// s_tuser fields: event_valid[0]
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata fields: sample[15:0]
	output logic [SAMPLE_BITS-1:0] m_tdata
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      pop_cmd;

	mnso_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mnso_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	mnso_back #(
		.SAMPLE_RATE    (SAMPLE_RATE),
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_cmd  (pop_cmd),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
